// File: hdl/tf_pkg.sv
package tf_pkg;

  // Fixed sizes of the key schedule.
  localparam int SUBKEY_COUNT = 40;
  localparam int SLOT_COUNT   = SUBKEY_COUNT / 2;
  localparam int ROUND_COUNT  = 16;

  // Field polynomials of the MDS and RS codes.
  localparam logic [8:0] MDS_POLY = 9'h169;
  localparam logic [8:0] RS_POLY  = 9'h14d;

  // Configuration register indexes.
  localparam logic [2:0] REG_KEY_0   = 3'd0;
  localparam logic [2:0] REG_KEY_1   = 3'd1;
  localparam logic [2:0] REG_KEY_2   = 3'd2;
  localparam logic [2:0] REG_KEY_3   = 3'd3;
  localparam logic [2:0] REG_KEY_LEN = 3'd4;
  localparam logic [2:0] REG_DIR     = 3'd5;

  localparam logic [5:0] KEY_LEN_MAX = 6'd32;

  // One 128-bit block as four 32-bit words.
  typedef logic [3:0][31:0] tf_blk_t;

  // Key-dependent material for the g function.
  typedef struct packed {
    logic [3:0][31:0] sbox;
    logic [2:0]       words;
  } tf_gkey_t;

  typedef enum logic [1:0] {
    SCHED_BUILD,
    SCHED_FLUSH,
    SCHED_READY
  } tf_sched_state_t;

  // Nibble tables of the q0 and q1 permutations.
  localparam logic [3:0] NIB [2][4][16] = '{
    '{'{4'h8,4'h1,4'h7,4'hD,4'h6,4'hF,4'h3,4'h2,4'h0,4'hB,4'h5,4'h9,4'hE,4'hC,4'hA,4'h4},
      '{4'hE,4'hC,4'hB,4'h8,4'h1,4'h2,4'h3,4'h5,4'hF,4'h4,4'hA,4'h6,4'h7,4'h0,4'h9,4'hD},
      '{4'hB,4'hA,4'h5,4'hE,4'h6,4'hD,4'h9,4'h0,4'hC,4'h8,4'hF,4'h3,4'h2,4'h4,4'h7,4'h1},
      '{4'hD,4'h7,4'hF,4'h4,4'h1,4'h2,4'h6,4'hE,4'h9,4'hB,4'h3,4'h0,4'h8,4'h5,4'hC,4'hA}},
    '{'{4'h2,4'h8,4'hB,4'hD,4'hF,4'h7,4'h6,4'hE,4'h3,4'h1,4'h9,4'h4,4'h0,4'hA,4'hC,4'h5},
      '{4'h1,4'hE,4'h2,4'hB,4'h4,4'hC,4'h3,4'h7,4'h6,4'hD,4'hA,4'h5,4'hF,4'h9,4'h0,4'h8},
      '{4'h4,4'hC,4'h7,4'h5,4'h1,4'h6,4'h9,4'hA,4'h0,4'hE,4'hD,4'h8,4'h2,4'hB,4'h3,4'hF},
      '{4'hB,4'h9,4'h5,4'h1,4'hC,4'h3,4'hD,4'hE,4'h6,4'h4,4'h7,4'hF,4'h2,4'h0,4'h8,4'hA}}};

  localparam logic [7:0] MDS_M [4][4] = '{
    '{8'h01,8'hEF,8'h5B,8'h5B}, '{8'h5B,8'hEF,8'hEF,8'h01},
    '{8'hEF,8'h5B,8'h01,8'hEF}, '{8'hEF,8'h01,8'hEF,8'h5B}};

  localparam logic [7:0] RS_M [4][8] = '{
    '{8'h01,8'hA4,8'h55,8'h87,8'h5A,8'h58,8'hDB,8'h9E},
    '{8'hA4,8'h56,8'h82,8'hF3,8'h1E,8'hC6,8'h68,8'hE5},
    '{8'h02,8'hA1,8'hFC,8'hC1,8'h47,8'hAE,8'h3D,8'h19},
    '{8'hA4,8'h55,8'h87,8'h5A,8'h58,8'hDB,8'h9E,8'h03}};

  function automatic logic [31:0] rotl(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // Byte permutation q0 or q1.
  function automatic logic [7:0] qperm(logic which, logic [7:0] x);
    logic [3:0] a, b, a1, b1;
    a  = x[7:4];
    b  = x[3:0];
    a1 = a ^ b;
    b1 = a ^ {b[0], b[3:1]} ^ {a[0], 3'b000};
    a  = NIB[which][0][a1];
    b  = NIB[which][1][b1];
    a1 = a ^ b;
    b1 = a ^ {b[0], b[3:1]} ^ {a[0], 3'b000};
    a  = NIB[which][2][a1];
    b  = NIB[which][3][b1];
    return {b, a};
  endfunction

  // Multiply in GF(2^8) under the given polynomial.
  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b, logic [8:0] poly);
    logic [7:0] r;
    logic [8:0] aa;
    r  = '0;
    aa = {1'b0, a};
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ aa[7:0];
      aa = {aa[7:0], 1'b0};
      if (aa[8]) aa = aa ^ poly;
    end
    return r;
  endfunction

  // The h function; l[0] is the outermost key word, k is 2, 3 or 4.
  function automatic logic [31:0] hfun(logic [31:0] x, logic [3:0][31:0] l, logic [2:0] k);
    logic [7:0] y [4];
    logic [7:0] s;
    logic [31:0] z;
    for (int i = 0; i < 4; i++) y[i] = x[8*i +: 8];
    if (k == 3'd4) begin
      y[0] = qperm(1'b1, y[0]) ^ l[3][7:0];
      y[1] = qperm(1'b0, y[1]) ^ l[3][15:8];
      y[2] = qperm(1'b0, y[2]) ^ l[3][23:16];
      y[3] = qperm(1'b1, y[3]) ^ l[3][31:24];
    end
    if (k >= 3'd3) begin
      y[0] = qperm(1'b1, y[0]) ^ l[2][7:0];
      y[1] = qperm(1'b1, y[1]) ^ l[2][15:8];
      y[2] = qperm(1'b0, y[2]) ^ l[2][23:16];
      y[3] = qperm(1'b0, y[3]) ^ l[2][31:24];
    end
    y[0] = qperm(1'b1, qperm(1'b0, qperm(1'b0, y[0]) ^ l[1][7:0]) ^ l[0][7:0]);
    y[1] = qperm(1'b0, qperm(1'b0, qperm(1'b1, y[1]) ^ l[1][15:8]) ^ l[0][15:8]);
    y[2] = qperm(1'b1, qperm(1'b1, qperm(1'b0, y[2]) ^ l[1][23:16]) ^ l[0][23:16]);
    y[3] = qperm(1'b0, qperm(1'b1, qperm(1'b1, y[3]) ^ l[1][31:24]) ^ l[0][31:24]);
    for (int i = 0; i < 4; i++) begin
      s = '0;
      for (int j = 0; j < 4; j++) s = s ^ gf_mul(y[j], MDS_M[i][j], MDS_POLY);
      z[8*i +: 8] = s;
    end
    return z;
  endfunction

  // Reed-Solomon word from eight key bytes.
  function automatic logic [31:0] rs_word(logic [63:0] kb);
    logic [7:0] v;
    logic [31:0] s;
    for (int r = 0; r < 4; r++) begin
      v = '0;
      for (int j = 0; j < 8; j++) v = v ^ gf_mul(kb[8*j +: 8], RS_M[r][j], RS_POLY);
      s[8*r +: 8] = v;
    end
    return s;
  endfunction

endpackage

// File: hdl/twofish_block_cipher.sv
// Twofish block cipher engine, one 128-bit block per beat.
// Configuration: write the key words, key length and direction through
// cfg_write/cfg_index/cfg_data while the engine is idle. Each write to one
// of these registers (index 0 to 5) starts a key schedule build: one subkey
// pair per cycle through a pair of h units, then a drain state; in_stall stays high meanwhile.
// After reset the schedule is built for the all-zero key the same way.
// Input channel: in_valid/in_stall with block_low and block_high; a beat is
// taken at an edge where in_valid is high and in_stall low.
// Output channel: out_valid/out_stall with result_low and result_high.
// The data path is a chain of 16 round cells between an input whitening
// register and an output whitening register; each cell registers its two g
// evaluations and then its Feistel mix, and a new block can be taken every
// cycle while the receiver does not stall and the schedule is ready.
// When the receiver stalls with a result waiting, the whole chain holds and
// in_stall rises in the same cycle; nothing is lost or repeated.
module twofish_block_cipher (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] block_low,
  input  logic [63:0] block_high,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] result_low,
  output logic [63:0] result_high
);
  import tf_pkg::*;

  logic                         sched_ready;
  tf_gkey_t                     gkey;
  logic [SLOT_COUNT-1:0][63:0]  sk;
  logic                         dir;
  logic                         adv;
  logic                         v0;
  tf_blk_t                      blk0;
  logic    [ROUND_COUNT:0]      cv;
  tf_blk_t                      cb [ROUND_COUNT+1];

  tf_key_sched u_sched (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ready     (sched_ready),
    .gkey      (gkey),
    .sk        (sk)
  );

  // Direction register mirrored here for the cells.
  always_ff @(posedge clk) begin
    if (rst)                                     dir <= 1'b0;
    else if (cfg_write && cfg_index == REG_DIR)  dir <= cfg_data[0];
  end

  // The chain moves when the output register is empty or being taken.
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !(adv && sched_ready);

  // Input whitening register.
  always_ff @(posedge clk) begin
    if (rst)      v0 <= 1'b0;
    else if (adv) v0 <= in_valid && !in_stall;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      blk0[0] <= block_low[31:0]   ^ sk[0][31:0];
      blk0[1] <= block_low[63:32]  ^ sk[0][63:32];
      blk0[2] <= block_high[31:0]  ^ sk[1][31:0];
      blk0[3] <= block_high[63:32] ^ sk[1][63:32];
    end
  end

  assign cv[0] = v0;
  assign cb[0] = blk0;

  // Sixteen round cells in a row.
  for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_round
    tf_round_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .dir       (dir),
      .gkey      (gkey),
      .round_key (sk[4+i]),
      .in_valid  (cv[i]),
      .in_blk    (cb[i]),
      .out_valid (cv[i+1]),
      .out_blk   (cb[i+1])
    );
  end

  // Output whitening register with the final half swap.
  always_ff @(posedge clk) begin
    if (rst)      out_valid <= 1'b0;
    else if (adv) out_valid <= cv[ROUND_COUNT];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result_low  <= {cb[ROUND_COUNT][3] ^ sk[2][63:32], cb[ROUND_COUNT][2] ^ sk[2][31:0]};
      result_high <= {cb[ROUND_COUNT][1] ^ sk[3][63:32], cb[ROUND_COUNT][0] ^ sk[3][31:0]};
    end
  end

  // A taken beat lands in the input register.
  assert property (@(posedge clk) disable iff (rst) (in_valid && !in_stall) |=> v0)
    else $error("accepted beat missing from input stage");

  // A write to the key length register forces a schedule rebuild.
  assert property (@(posedge clk) disable iff (rst)
    (cfg_write && cfg_index == REG_KEY_LEN) |=> !sched_ready)
    else $error("schedule still ready after a key write");

  // A new result comes only from the last round cell.
  assert property (@(posedge clk) disable iff (rst) $rose(out_valid) |-> $past(cv[ROUND_COUNT]))
    else $error("result appeared without a finished round");

endmodule

// File: hdl/tf_key_sched.sv
module tf_key_sched (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_write,
  input  logic [2:0]                              cfg_index,
  input  logic [63:0]                             cfg_data,
  output logic                                    ready,
  output tf_pkg::tf_gkey_t                        gkey,
  output logic [tf_pkg::SLOT_COUNT-1:0][63:0]     sk
);
  import tf_pkg::*;

  logic [3:0][63:0] key;
  logic [5:0]       key_len;
  logic             dir;
  tf_sched_state_t  state, state_next;
  logic [4:0]       pair_cnt;
  logic             build_en;
  logic             restart;

  logic             pend_valid;
  logic [4:0]       pend_pair;
  logic [31:0]      pend_a, pend_b;

  logic [255:0]     km;
  logic [3:0][31:0] me, mo;
  logic [2:0]       words;
  logic [3:0][31:0] sbox_calc;
  logic [1:0]       src;
  logic [4:0]       slot, rnd;
  logic [7:0]       even_idx, odd_idx;

  // Every write to a known register invalidates the schedule.
  assign restart = cfg_write && (cfg_index <= REG_DIR);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      key     <= '0;
      key_len <= '0;
      dir     <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KEY_0, REG_KEY_1, REG_KEY_2, REG_KEY_3: key[cfg_index[1:0]] <= cfg_data;
        REG_KEY_LEN: key_len <= (cfg_data[5:0] > KEY_LEN_MAX) ? KEY_LEN_MAX : cfg_data[5:0];
        REG_DIR:     dir     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Zero-padded key, its even and odd words, and the word count.
  always_comb begin
    for (int j = 0; j < 32; j++)
      km[8*j +: 8] = (6'(j) < key_len) ? key[j/8][8*(j%8) +: 8] : 8'h00;
    for (int i = 0; i < 4; i++) begin
      me[i] = km[64*i +: 32];
      mo[i] = km[64*i+32 +: 32];
    end
    if (key_len <= 6'd16)      words = 3'd2;
    else if (key_len <= 6'd24) words = 3'd3;
    else                       words = 3'd4;
  end

  // S words in g order: slot s holds the RS word of key block k-1-s.
  always_comb begin
    for (int s = 0; s < 4; s++) begin
      src = 2'(words - 3'd1 - 3'(s));
      sbox_calc[s] = (3'(s) < words) ? rs_word(km[64*src +: 64]) : 32'h0;
    end
  end

  // Next state of the schedule sequencer.
  always_comb begin
    state_next = state;
    priority if (restart) state_next = SCHED_BUILD;
    else begin
      unique case (state)
        SCHED_BUILD: if (pair_cnt == 5'(SLOT_COUNT - 1)) state_next = SCHED_FLUSH;
        SCHED_FLUSH: state_next = SCHED_READY;
        SCHED_READY: state_next = SCHED_READY;
        default:     state_next = SCHED_BUILD;
      endcase
    end
  end

  // Sequencer outputs.
  always_comb begin
    build_en = (state == SCHED_BUILD);
    ready    = (state == SCHED_READY);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= SCHED_BUILD;
      pair_cnt   <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      pend_valid <= build_en && !restart;
      if (restart)       pair_cnt <= '0;
      else if (build_en) pair_cnt <= pair_cnt + 5'd1;
    end
  end

  // First step: the two h evaluations of one subkey pair.
  assign even_idx = {2'b00, pair_cnt, 1'b0};
  assign odd_idx  = {2'b00, pair_cnt, 1'b1};

  always_ff @(posedge clk) begin
    if (build_en) begin
      pend_pair <= pair_cnt;
      pend_a    <= hfun({4{even_idx}}, me, words);
      pend_b    <= rotl(hfun({4{odd_idx}}, mo, words), 8);
      gkey.sbox  <= sbox_calc;
      gkey.words <= words;
    end
  end

  // Subkeys are stored in order of use, so each round reads a fixed slot.
  always_comb begin
    rnd = pend_pair - 5'd4;
    if (pend_pair < 5'd4) slot = dir ? (pend_pair ^ 5'd2) : pend_pair;
    else                  slot = 5'd4 + (dir ? (5'd15 - rnd) : rnd);
  end

  // Second step: PHT and rotation, written into the subkey slot.
  always_ff @(posedge clk) begin
    if (pend_valid)
      sk[slot] <= {rotl(pend_a + {pend_b[30:0], 1'b0}, 9), pend_a + pend_b};
  end

endmodule

// File: hdl/tf_round_cell.sv
module tf_round_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             dir,
  input  tf_pkg::tf_gkey_t gkey,
  input  logic [63:0]      round_key,
  input  logic             in_valid,
  input  tf_pkg::tf_blk_t  in_blk,
  output logic             out_valid,
  output tf_pkg::tf_blk_t  out_blk
);
  import tf_pkg::*;

  logic        a_valid;
  tf_blk_t     a_blk;
  logic [31:0] t0, t1, f0, f1, n0, n1;

  // First half: the two g evaluations.
  always_ff @(posedge clk) begin
    if (rst)     a_valid <= 1'b0;
    else if (en) a_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_blk <= in_blk;
      t0    <= hfun(in_blk[0], gkey.sbox, gkey.words);
      t1    <= hfun(rotl(in_blk[1], 8), gkey.sbox, gkey.words);
    end
  end

  // Second half: PHT with round keys and the Feistel mix.
  always_comb begin
    f0 = t0 + t1 + round_key[31:0];
    f1 = t0 + {t1[30:0], 1'b0} + round_key[63:32];
    if (dir) begin
      n0 = rotl(a_blk[2], 1) ^ f0;
      n1 = rotl(a_blk[3] ^ f1, 31);
    end else begin
      n0 = rotl(a_blk[2] ^ f0, 31);
      n1 = rotl(a_blk[3], 1) ^ f1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst)     out_valid <= 1'b0;
    else if (en) out_valid <= a_valid;
  end

  always_ff @(posedge clk) begin
    if (en) out_blk <= {a_blk[1], a_blk[0], n1, n0};
  end

endmodule

// File: dv/tb.sv
module tb;
  import tf_pkg::*;

  typedef struct {
    logic [63:0] lo;
    logic [63:0] hi;
  } blk_t;

  localparam int PHASES = 11;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [63:0] block_low = '0;
  logic [63:0] block_high = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [63:0] result_low;
  logic [63:0] result_high;

  twofish_block_cipher uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .block_low(block_low), .block_high(block_high),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_low(result_low), .result_high(result_high)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow of the key registers and the derived schedule.
  logic [63:0] key_reg [4];
  int unsigned key_len;
  logic decrypt;
  int unsigned key_words;
  logic [31:0] subkey [SUBKEY_COUNT];
  logic [3:0][31:0] s_words;

  blk_t pending_blocks[$];
  blk_t expected_blocks[$];
  int errors = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  bit busy_phase = 1'b0;

  function automatic logic [31:0] rol32(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // Byte permutation built from the four nibble tables.
  function automatic logic [7:0] q_byte(int which, logic [7:0] x);
    logic [3:0] hi_n, lo_n, t0, t1;
    hi_n = x[7:4];
    lo_n = x[3:0];
    for (int st = 0; st < 2; st++) begin
      t0 = hi_n ^ lo_n;
      t1 = hi_n ^ {lo_n[0], lo_n[3:1]} ^ {hi_n[0], 3'b000};
      hi_n = NIB[which][2 * st][t0];
      lo_n = NIB[which][2 * st + 1][t1];
    end
    return {lo_n, hi_n};
  endfunction

  function automatic logic [7:0] field_mul(logic [7:0] a, logic [7:0] b, logic [8:0] poly);
    logic [8:0] acc;
    logic [7:0] prod;
    acc = {1'b0, a};
    prod = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) prod ^= acc[7:0];
      acc = acc << 1;
      if (acc[8]) acc ^= poly;
    end
    return prod;
  endfunction

  // Keyed h mixing: chains of q permutations, then the MDS product.
  function automatic logic [31:0] h_mix(logic [31:0] x, logic [3:0][31:0] kw, int k);
    logic [7:0] y [4];
    logic [7:0] acc;
    logic [31:0] z;
    for (int i = 0; i < 4; i++) y[i] = x[8*i +: 8];
    if (k == 4) begin
      y[0] = q_byte(1, y[0]) ^ kw[3][7:0];
      y[1] = q_byte(0, y[1]) ^ kw[3][15:8];
      y[2] = q_byte(0, y[2]) ^ kw[3][23:16];
      y[3] = q_byte(1, y[3]) ^ kw[3][31:24];
    end
    if (k >= 3) begin
      y[0] = q_byte(1, y[0]) ^ kw[2][7:0];
      y[1] = q_byte(1, y[1]) ^ kw[2][15:8];
      y[2] = q_byte(0, y[2]) ^ kw[2][23:16];
      y[3] = q_byte(0, y[3]) ^ kw[2][31:24];
    end
    y[0] = q_byte(1, q_byte(0, q_byte(0, y[0]) ^ kw[1][7:0]) ^ kw[0][7:0]);
    y[1] = q_byte(0, q_byte(0, q_byte(1, y[1]) ^ kw[1][15:8]) ^ kw[0][15:8]);
    y[2] = q_byte(1, q_byte(1, q_byte(0, y[2]) ^ kw[1][23:16]) ^ kw[0][23:16]);
    y[3] = q_byte(0, q_byte(1, q_byte(1, y[3]) ^ kw[1][31:24]) ^ kw[0][31:24]);
    for (int i = 0; i < 4; i++) begin
      acc = '0;
      for (int j = 0; j < 4; j++) acc ^= field_mul(y[j], MDS_M[i][j], MDS_POLY);
      z[8*i +: 8] = acc;
    end
    return z;
  endfunction

  function automatic logic [7:0] key_octet(int j);
    if (j >= key_len) return 8'h00;
    return key_reg[j / 8][8*(j % 8) +: 8];
  endfunction

  function automatic logic [31:0] key_quad(int w);
    logic [31:0] q;
    for (int i = 0; i < 4; i++) q[8*i +: 8] = key_octet(4 * w + i);
    return q;
  endfunction

  // Subkeys from the even and odd key words, S words from the RS code.
  function automatic void build_schedule();
    logic [3:0][31:0] even_w, odd_w;
    logic [31:0] a, b, sw;
    logic [7:0] v;
    even_w = '0;
    odd_w = '0;
    key_words = (key_len + 7) / 8;
    if (key_words < 2) key_words = 2;
    for (int i = 0; i < key_words; i++) begin
      even_w[i] = key_quad(2 * i);
      odd_w[i] = key_quad(2 * i + 1);
    end
    for (int i = 0; i < SUBKEY_COUNT; i += 2) begin
      a = h_mix(32'h01010101 * i, even_w, key_words);
      b = rol32(h_mix(32'h01010101 * (i + 1), odd_w, key_words), 8);
      subkey[i] = a + b;
      subkey[i + 1] = rol32(a + 2 * b, 9);
    end
    s_words = '0;
    for (int i = 0; i < key_words; i++) begin
      for (int r = 0; r < 4; r++) begin
        v = '0;
        for (int j = 0; j < 8; j++) v ^= field_mul(key_octet(8 * i + j), RS_M[r][j], RS_POLY);
        sw[8*r +: 8] = v;
      end
      s_words[key_words - 1 - i] = sw;
    end
  endfunction

  // Sixteen Feistel rounds with whitening on both ends.
  function automatic blk_t cipher_block(blk_t src);
    logic [31:0] w [4];
    logic [31:0] t0, t1, n0, n1;
    int wi, wo, r;
    blk_t dst;
    wi = decrypt ? 4 : 0;
    wo = decrypt ? 0 : 4;
    w[0] = src.lo[31:0] ^ subkey[wi];
    w[1] = src.lo[63:32] ^ subkey[wi + 1];
    w[2] = src.hi[31:0] ^ subkey[wi + 2];
    w[3] = src.hi[63:32] ^ subkey[wi + 3];
    for (int i = 0; i < 16; i++) begin
      r = decrypt ? 15 - i : i;
      t0 = h_mix(w[0], s_words, key_words);
      t1 = h_mix(rol32(w[1], 8), s_words, key_words);
      if (decrypt) begin
        n0 = rol32(w[2], 1) ^ (t0 + t1 + subkey[2 * r + 8]);
        n1 = rol32(w[3] ^ (t0 + 2 * t1 + subkey[2 * r + 9]), 31);
      end else begin
        n0 = rol32(w[2] ^ (t0 + t1 + subkey[2 * r + 8]), 31);
        n1 = rol32(w[3], 1) ^ (t0 + 2 * t1 + subkey[2 * r + 9]);
      end
      w[2] = w[0];
      w[3] = w[1];
      w[0] = n0;
      w[1] = n1;
    end
    dst.lo = {w[3] ^ subkey[wo + 1], w[2] ^ subkey[wo]};
    dst.hi = {w[1] ^ subkey[wo + 3], w[0] ^ subkey[wo + 2]};
    return dst;
  endfunction

  // Mostly short gaps, a few long ones, none in busy phases.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (busy_phase) return 0;
    if (roll < 60) return 0;
    if (roll < 94) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [63:0] pick_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 64'h1 << $urandom_range(63);
      3: return ~(64'h1 << $urandom_range(63));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Sender: offers queued beats and predicts each accepted one.
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_blocks.push_back(cipher_block('{lo: block_low, hi: block_high}));
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_blocks.size() > 0) begin
          block_low <= pending_blocks[0].lo;
          block_high <= pending_blocks[0].hi;
          void'(pending_blocks.pop_front());
          in_valid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result beat and stalls at random, once for long.
  int hold_left = 0;
  bit squeezed = 1'b0;
  blk_t want;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_blocks.size() == 0) begin
          errors++;
          $error("result beat with no block outstanding: %h %h", result_high, result_low);
        end else begin
          want = expected_blocks.pop_front();
          if (result_low !== want.lo) begin
            errors++;
            $error("result_low: expected %h, got %h", want.lo, result_low);
          end
          if (result_high !== want.hi) begin
            errors++;
            $error("result_high: expected %h, got %h", want.hi, result_high);
          end
        end
      end
      if (!squeezed && results_seen >= 300) begin
        squeezed = 1'b1;
        hold_left = 400;
      end else if (hold_left == 0) begin
        hold_left = pick_gap();
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles where neither channel moves a beat.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("twofish_block_cipher regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx <= REG_KEY_3) begin
      key_reg[idx] = data;
    end else if (idx == REG_KEY_LEN) begin
      key_len = data[5:0];
      if (key_len > KEY_LEN_MAX) key_len = KEY_LEN_MAX;
    end else if (idx == REG_DIR) begin
      decrypt = data[0];
    end
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Key length per phase (direction alternates with the phase); extremes first.
  int phase_len [PHASES] = '{0, 16, 32, 63, 24, 17, 25, 1, 8, 31, 40};
  int n_items;
  logic [63:0] kfill;

  initial begin
    for (int i = 0; i < 4; i++) key_reg[i] = '0;
    key_len = 0;
    decrypt = 1'b0;
    build_schedule();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      // The first phase runs on the reset key; later ones reprogram it.
      if (p > 0) begin
        for (int i = 0; i < 4; i++) begin
          kfill = (p == 2) ? '1 : pick_word();
          write_reg(REG_KEY_0 + 3'(i), kfill);
        end
        write_reg(REG_KEY_LEN, 64'(phase_len[p]));
        write_reg(REG_DIR, 64'(p % 2));
        if (p == 5) write_reg(3'd6, pick_word());
        if (p == 7) write_reg(3'd7, pick_word());
        build_schedule();
      end
      busy_phase = (p % 3 == 2);
      if (p == 0) begin
        pending_blocks.push_back('{lo: '0, hi: '0});
        pending_blocks.push_back('{lo: '1, hi: '1});
        pending_blocks.push_back('{lo: 64'h5555555555555555, hi: 64'haaaaaaaaaaaaaaaa});
        pending_blocks.push_back('{lo: 64'haaaaaaaaaaaaaaaa, hi: 64'h5555555555555555});
        pending_blocks.push_back('{lo: 64'h1, hi: 64'h0});
        pending_blocks.push_back('{lo: 64'h0, hi: 64'h8000000000000000});
        pending_blocks.push_back('{lo: 64'h0706050403020100, hi: 64'h0f0e0d0c0b0a0908});
        pending_blocks.push_back('{lo: '1, hi: '0});
      end
      n_items = (p == 0) ? 40 : 100;
      for (int i = 0; i < n_items; i++) begin
        pending_blocks.push_back('{lo: pick_word(), hi: pick_word()});
      end
      while (pending_blocks.size() > 0 || in_valid || expected_blocks.size() > 0) begin
        @(posedge clk);
      end
      repeat (DRAIN_CYCLES) @(posedge clk);
    end
    if (errors == 0) begin
      $display("twofish_block_cipher regression: pass");
    end else begin
      $display("twofish_block_cipher regression: fail");
    end
    $finish;
  end

endmodule
